// ===== hw/rtl/sdm_pkg.sv =====
// ---------------------------------------------------------------------------
// sdm_pkg: shared types and constants of the scrolling dot-matrix driver
// Holds the mode codes, configuration register indexes, scroll timing
// constants and the structure that carries the configuration registers.
// ---------------------------------------------------------------------------
`default_nettype none

package sdm_pkg;

    // Scroll period in ticks and number of configured scroll frames.
    localparam int SCROLL_TICKS  = 100;
    localparam int SCROLL_FRAMES = 2;

    localparam int ELAPSED_W = $clog2(SCROLL_TICKS + 1);
    localparam int POS_W     = 2;
    localparam int SHIFT_W   = 3;
    localparam int COL_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 2;
    localparam int FLOOR_W   = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOP = 2'd0,
        MODE_UP   = 2'd1,
        MODE_DOWN = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLYPH_ONE   = 3'd0,
        CFG_GLYPH_TWO   = 3'd1,
        CFG_GLYPH_THREE = 3'd2,
        CFG_GLYPH_FOUR  = 3'd3,
        CFG_UP_A        = 3'd4,
        CFG_UP_B        = 3'd5,
        CFG_DOWN_A      = 3'd6,
        CFG_DOWN_B      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [WORD_W-1:0] glyph_one;
        logic [WORD_W-1:0] glyph_two;
        logic [WORD_W-1:0] glyph_three;
        logic [WORD_W-1:0] glyph_four;
        logic [WORD_W-1:0] up_a;
        logic [WORD_W-1:0] up_b;
        logic [WORD_W-1:0] down_a;
        logic [WORD_W-1:0] down_b;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/sdm_cfg.sv =====
// ---------------------------------------------------------------------------
// sdm_cfg: configuration register bank
// Eight 64-bit registers holding the floor glyphs and the scroll frames,
// written through a plain write port.
// ---------------------------------------------------------------------------
`default_nettype none

module sdm_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sdm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sdm_pkg::WORD_W-1:0]    i_cfg_data,
    output sdm_pkg::t_cfg                      o_cfg
);

    sdm_pkg::t_cfg r_cfg;
    sdm_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (sdm_pkg::t_cfg_idx'(i_cfg_index))
                sdm_pkg::CFG_GLYPH_ONE:   n_cfg.glyph_one   = i_cfg_data;
                sdm_pkg::CFG_GLYPH_TWO:   n_cfg.glyph_two   = i_cfg_data;
                sdm_pkg::CFG_GLYPH_THREE: n_cfg.glyph_three = i_cfg_data;
                sdm_pkg::CFG_GLYPH_FOUR:  n_cfg.glyph_four  = i_cfg_data;
                sdm_pkg::CFG_UP_A:        n_cfg.up_a        = i_cfg_data;
                sdm_pkg::CFG_UP_B:        n_cfg.up_b        = i_cfg_data;
                sdm_pkg::CFG_DOWN_A:      n_cfg.down_a      = i_cfg_data;
                sdm_pkg::CFG_DOWN_B:      n_cfg.down_b      = i_cfg_data;
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/sdm_scroll.sv =====
// ---------------------------------------------------------------------------
// sdm_scroll: one scroll animation channel
// Keeps the shift, frame position, period counter and display of one scroll
// direction; it loads the glyph, or rebuilds the display when the period ends.
// ---------------------------------------------------------------------------
`default_nettype none

module sdm_scroll (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic                       i_load,
    input  wire logic                       i_leftward,
    input  wire logic [sdm_pkg::WORD_W-1:0] i_glyph,
    input  wire logic [sdm_pkg::WORD_W-1:0] i_frame_a,
    input  wire logic [sdm_pkg::WORD_W-1:0] i_frame_b,
    output logic      [sdm_pkg::WORD_W-1:0] o_display_next
);

    logic [sdm_pkg::SHIFT_W-1:0]   r_shift,   n_shift;
    logic [sdm_pkg::POS_W-1:0]     r_pos,     n_pos;
    logic [sdm_pkg::ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [sdm_pkg::WORD_W-1:0]    r_display, n_display;

    logic [sdm_pkg::WORD_W-1:0] word_cur;
    logic [sdm_pkg::WORD_W-1:0] word_nxt;
    logic [sdm_pkg::WORD_W-1:0] rebuilt;
    logic [sdm_pkg::POS_W-1:0]  pos_nxt;
    logic [sdm_pkg::ELAPSED_W-1:0] elapsed_inc;
    logic                       period_end;

    // Frames beyond the configured count read as blank.
    function automatic logic [sdm_pkg::WORD_W-1:0] frame_word(
        input logic [sdm_pkg::POS_W-1:0]  pos,
        input logic [sdm_pkg::WORD_W-1:0] glyph,
        input logic [sdm_pkg::WORD_W-1:0] fa,
        input logic [sdm_pkg::WORD_W-1:0] fb
    );
        logic [sdm_pkg::WORD_W-1:0] w;
        unique case (pos)
            2'd0:    w = glyph;
            2'd1:    w = (sdm_pkg::SCROLL_FRAMES >= 1) ? fa : '0;
            2'd2:    w = (sdm_pkg::SCROLL_FRAMES >= 2) ? fb : '0;
            default: w = '0;
        endcase
        return w;
    endfunction

    assign pos_nxt  = r_pos + 1'b1;
    assign word_cur = frame_word(r_pos, i_glyph, i_frame_a, i_frame_b);
    assign word_nxt = frame_word(pos_nxt, i_glyph, i_frame_a, i_frame_b);

    // Each byte is built from the current and the following frame: a 16-bit
    // window slid by the shift count picks the bits.
    always_comb begin
        logic [2*sdm_pkg::BYTE_W-1:0] win;
        rebuilt = '0;
        for (int k = 0; k < sdm_pkg::WORD_W / sdm_pkg::BYTE_W; k++) begin
            if (i_leftward) begin
                win = {word_cur[k*sdm_pkg::BYTE_W +: sdm_pkg::BYTE_W],
                       word_nxt[k*sdm_pkg::BYTE_W +: sdm_pkg::BYTE_W]} << r_shift;
                rebuilt[k*sdm_pkg::BYTE_W +: sdm_pkg::BYTE_W] =
                    win[2*sdm_pkg::BYTE_W-1:sdm_pkg::BYTE_W];
            end else begin
                win = {word_nxt[k*sdm_pkg::BYTE_W +: sdm_pkg::BYTE_W],
                       word_cur[k*sdm_pkg::BYTE_W +: sdm_pkg::BYTE_W]} >> r_shift;
                rebuilt[k*sdm_pkg::BYTE_W +: sdm_pkg::BYTE_W] =
                    win[sdm_pkg::BYTE_W-1:0];
            end
        end
    end

    assign elapsed_inc = r_elapsed + 1'b1;
    assign period_end  = (elapsed_inc == sdm_pkg::ELAPSED_W'(sdm_pkg::SCROLL_TICKS));

    always_comb begin
        n_shift   = r_shift;
        n_pos     = r_pos;
        n_elapsed = r_elapsed;
        n_display = r_display;
        if (i_load) begin
            n_display = i_glyph;
        end else if (i_step) begin
            if (period_end) begin
                n_elapsed = '0;
                n_display = rebuilt;
                n_shift   = r_shift + 1'b1;
                if (r_shift == '1) begin
                    if (r_pos == sdm_pkg::POS_W'(sdm_pkg::SCROLL_FRAMES)) begin
                        n_pos = '0;
                    end else begin
                        n_pos = pos_nxt;
                    end
                end
            end else begin
                n_elapsed = elapsed_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift   <= '0;
            r_pos     <= '0;
            r_elapsed <= '0;
            r_display <= '0;
        end else begin
            r_shift   <= n_shift;
            r_pos     <= n_pos;
            r_elapsed <= n_elapsed;
            r_display <= n_display;
        end
    end

    assign o_display_next = n_display;

endmodule

`default_nettype wire

// ===== hw/rtl/scrolling_dot_matrix_driver_top.sv =====
// ---------------------------------------------------------------------------
// scrolling_dot_matrix_driver_top: multiplexed 8x8 LED matrix driver
// Takes one tick request per millisecond carrying the mode and floor, and
// returns one column drive and its row byte per request, scrolling the floor
// glyph up or down through configured frames.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   --------  ---------  -------------------------  ---------------------------
//   tick in   input      i_in_valid / o_in_stall    i_mode, i_floor
//   column    output     o_out_valid / i_out_stall  o_column_drive, o_row_drive
//   config    input      i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// Each request is held in the input register and moves to the result register
// once that is free or being emptied, where its result is presented. A new
// request can be taken every cycle while the result side does not stall;
// throughput is set by the single processing stage. Reset is synchronous and
// active low; it clears the valid flags, the scan column, the displays and the
// configuration registers, but not the held request or result data. A stall on
// the result side holds the result register; the input register still takes
// one further request, after which o_in_stall rises until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module scrolling_dot_matrix_driver_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tick requests
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [sdm_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [sdm_pkg::FLOOR_W-1:0]   i_floor,
    // column results
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [sdm_pkg::BYTE_W-1:0]    o_column_drive,
    output logic      [sdm_pkg::BYTE_W-1:0]    o_row_drive,
    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [sdm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sdm_pkg::WORD_W-1:0]    i_cfg_data
);

    sdm_pkg::t_cfg cfg;

    // Input register.
    logic                            r_in_valid, n_in_valid;
    logic [sdm_pkg::MODE_W-1:0]      r_in_mode;
    logic [sdm_pkg::FLOOR_W-1:0]     r_in_floor;

    // Scan column and result register.
    logic [sdm_pkg::COL_W-1:0]       r_col, n_col;
    logic                            r_out_valid, n_out_valid;
    logic [sdm_pkg::BYTE_W-1:0]      r_out_column;
    logic [sdm_pkg::BYTE_W-1:0]      r_out_row;

    logic                            in_accept;
    logic                            advance;
    logic [sdm_pkg::WORD_W-1:0]      glyph;
    logic [sdm_pkg::WORD_W-1:0]      up_next;
    logic [sdm_pkg::WORD_W-1:0]      down_next;
    logic [sdm_pkg::WORD_W-1:0]      shown;
    logic                            up_step;
    logic                            down_step;
    logic                            stop_load;

    sdm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The held request is processed when the result register is free or is
    // being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Floor numbers outside one to four saturate to the nearest end.
    always_comb begin
        unique case (r_in_floor)
            3'd0, 3'd1: glyph = cfg.glyph_one;
            3'd2:       glyph = cfg.glyph_two;
            3'd3:       glyph = cfg.glyph_three;
            default:    glyph = cfg.glyph_four;
        endcase
    end

    // Mode three behaves as stop.
    always_comb begin
        up_step   = 1'b0;
        down_step = 1'b0;
        stop_load = 1'b0;
        unique case (sdm_pkg::t_mode'(r_in_mode))
            sdm_pkg::MODE_UP:   up_step   = advance;
            sdm_pkg::MODE_DOWN: down_step = advance;
            default:            stop_load = advance;
        endcase
    end

    sdm_scroll u_up (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (up_step),
        .i_load         (1'b0),
        .i_leftward     (1'b1),
        .i_glyph        (glyph),
        .i_frame_a      (cfg.up_a),
        .i_frame_b      (cfg.up_b),
        .o_display_next (up_next)
    );

    sdm_scroll u_down (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (down_step),
        .i_load         (stop_load),
        .i_leftward     (1'b0),
        .i_glyph        (glyph),
        .i_frame_a      (cfg.down_a),
        .i_frame_b      (cfg.down_b),
        .o_display_next (down_next)
    );

    // The column is shown after any rebuild, so the next display contents
    // are used. Only up mode shows the up display.
    assign shown = (sdm_pkg::t_mode'(r_in_mode) == sdm_pkg::MODE_UP) ? up_next : down_next;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        n_col       = r_col;
        if (advance) begin
            n_in_valid = 1'b0;
        end
        if (in_accept) begin
            n_in_valid = 1'b1;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (advance) begin
            n_out_valid = 1'b1;
            n_col       = r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_col       <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_col       <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_mode  <= i_mode;
            r_in_floor <= i_floor;
        end
        if (advance) begin
            r_out_column <= ~(sdm_pkg::BYTE_W'(1) << r_col);
            r_out_row    <= shown[r_col*sdm_pkg::BYTE_W +: sdm_pkg::BYTE_W];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_column_drive = r_out_column;
    assign o_row_drive    = r_out_row;

endmodule

`default_nettype wire
